// ===== rtl/core/svr_pkg.sv =====
`timescale 1ns / 1ps
package svr_pkg;

  localparam logic OP_TRAIN   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  localparam logic [1:0] TUBE_INSIDE = 2'd0;
  localparam logic [1:0] TUBE_ABOVE  = 2'd1;
  localparam logic [1:0] TUBE_BELOW  = 2'd2;

  localparam logic CFG_LAMBDA  = 1'b0;
  localparam logic CFG_EPSILON = 1'b1;

  localparam logic [30:0] LAMBDA_RESET  = 31'd65;
  localparam logic [30:0] EPSILON_RESET = 31'd6554;
  localparam logic [30:0] ETA_MAX       = 31'h7FFF_FFFF;
  localparam logic signed [32:0] Q16_ONE = 33'sd65536;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] q32_t;

  function automatic q16_t sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  function automatic q16_t add_sat32(input q16_t a, input q16_t b);
    add_sat32 = sat33({a[31], a} + {b[31], b});
  endfunction

  // Q32.32 to Q16.16: floor plus the half bit, then saturate.
  function automatic q16_t round_q16(input q32_t a);
    logic signed [48:0] fl;
    fl = {a[63], a[63:16]} + {48'd0, a[15]};
    if (fl > 49'sh0_7FFF_FFFF) begin
      round_q16 = 32'sh7FFF_FFFF;
    end else if (fl < -49'sh0_8000_0000) begin
      round_q16 = 32'sh8000_0000;
    end else begin
      round_q16 = fl[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/svr_if.sv =====
`timescale 1ns / 1ps
interface svr_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] feature_value;
  logic [31:0] target_value;
  logic        last_feature;
  logic        epoch_start;
  logic        clear_model;

  modport source (output valid, operation, feature_value, target_value, last_feature,
                  epoch_start, clear_model, input ready);
  modport sink (input valid, operation, feature_value, target_value, last_feature,
                epoch_start, clear_model, output ready);
endinterface

interface svr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] model_output;
  logic [1:0]  tube_status;

  modport source (output valid, kind, model_output, tube_status, input ready);
  modport sink (input valid, kind, model_output, tube_status, output ready);
endinterface

// ===== rtl/core/svr_sgd_trainer_core.sv =====
`timescale 1ns / 1ps
// Linear epsilon-insensitive regressor trained by stochastic gradient descent in
// Q16.16. One feature is taken per request, and in_ch.ready stays low while it goes
// through weight memory read, multiply and accumulate. On the last feature of a
// prediction sample the result passes through states S_FIN and S_DONE. On the last
// feature of a training sample the step size is found by a bit-serial divider, and
// the weight update then walks the sample's features through the weight and sample
// memories, each through states S_WRD, S_WM1, S_WM2 and S_WWR.
// Weights reset to zero through per-entry valid bits, so there is no clearing pass.
module svr_sgd_trainer_core import svr_pkg::*; #(
  parameter int MAX_FEATURES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  svr_in_if.sink           in_ch,
  svr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [30:0]      cfg_data
);

  localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW = $clog2(MAX_FEATURES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_FEATURES);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_ACC, S_FIN, S_MUL, S_DIV, S_SHR1, S_SHR2,
    S_WRD, S_WM1, S_WM2, S_WWR, S_DONE
  } state_t;

  state_t state_r;

  logic [30:0] lambda_r, eps_r;
  logic [PW-1:0] pos_r, idx_r;
  q32_t acc_r, prod_r, prod2_r;
  logic [31:0] step_r;
  q16_t bias_r, pred_r, shrink_r, w1_r, x_r, target_r;
  logic op_r, last_r;
  logic [30:0] eta_r;
  logic [63:0] el_r;
  logic signed [32:0] alpha_r;
  logic [1:0] status_r;

  logic out_valid_r, out_kind_r;
  q16_t out_value_r;
  logic [1:0] out_status_r;
  logic out_load;

  // Weight and sample memories.
  q16_t wmem [MAX_FEATURES];
  q16_t bmem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] wvalid_r;
  q16_t w_q, b_q;
  logic wv_q;
  logic [IW-1:0] raddr;
  logic w_we;
  q16_t w_wdata;
  logic b_we;

  logic accept, clear_now, div_start, div_done;
  logic [30:0] div_eta;
  q16_t w_cur, w_new;
  logic signed [33:0] resid;
  q32_t acc_sum;
  logic [64:0] acc_wide;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign clear_now = accept && (pos_r == '0) && in_ch.clear_model;
  assign raddr     = (state_r == S_IDLE) ? pos_r[IW-1:0] : idx_r[IW-1:0];
  assign b_we      = accept && (pos_r < POS_MAX);
  assign w_we      = (state_r == S_WWR);
  assign div_start = (state_r == S_MUL);
  assign w_cur     = wv_q ? w_q : '0;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    acc_wide = {acc_r[63], acc_r} + {prod_r[63], prod_r};
    if (acc_wide[64] != acc_wide[63]) begin
      acc_sum = acc_wide[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_sum = acc_wide[63:0];
    end
    resid   = {{2{pred_r[31]}}, pred_r} - {{2{target_r[31]}}, target_r};
    w_new   = (alpha_r != '0) ? add_sat32(w1_r, round_q16(prod2_r)) : w1_r;
    w_wdata = w_new;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[idx_r[IW-1:0]] <= w_wdata;
    end
    if (b_we) begin
      bmem[pos_r[IW-1:0]] <= in_ch.feature_value;
    end
    w_q <= wmem[raddr];
    b_q <= bmem[raddr];
  end

  svr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (lambda_r * step_r),
    .done    (div_done),
    .eta     (div_eta)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lambda_r    <= LAMBDA_RESET;
      eps_r       <= EPSILON_RESET;
      pos_r       <= '0;
      idx_r       <= '0;
      acc_r       <= '0;
      step_r      <= '0;
      bias_r      <= '0;
      wvalid_r    <= '0;
      wv_q        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LAMBDA) begin
          lambda_r <= cfg_data;
        end else begin
          eps_r <= cfg_data;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      wv_q <= wvalid_r[raddr] && !clear_now;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r     <= in_ch.operation;
            x_r      <= in_ch.feature_value;
            target_r <= in_ch.target_value;
            last_r   <= in_ch.last_feature;
            if (pos_r == '0) begin
              if (in_ch.epoch_start) begin
                step_r <= '0;
              end
              if (in_ch.clear_model) begin
                wvalid_r <= '0;
                bias_r   <= '0;
              end
            end
            if (pos_r < POS_MAX) begin
              state_r <= S_MAC;
            end else if (in_ch.last_feature) begin
              state_r <= S_FIN;
            end
          end
        end
        S_MAC: begin
          prod_r  <= w_cur * x_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_sum;
          pos_r   <= pos_r + PW'(1);
          state_r <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          pred_r   <= add_sat32(round_q16(acc_r), bias_r);
          status_r <= TUBE_INSIDE;
          if (op_r == OP_PREDICT) begin
            state_r <= S_DONE;
          end else begin
            if (step_r != 32'hFFFF_FFFF) begin
              step_r <= step_r + 32'd1;
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            eta_r   <= div_eta;
            state_r <= S_SHR1;
          end
        end
        S_SHR1: begin
          el_r <= {2'd0, 62'(eta_r) * 62'(lambda_r)};
          if (resid > $signed({3'd0, eps_r})) begin
            alpha_r  <= -$signed({2'd0, eta_r});
            status_r <= TUBE_ABOVE;
          end else if (resid < -$signed({3'd0, eps_r})) begin
            alpha_r  <= $signed({2'd0, eta_r});
            status_r <= TUBE_BELOW;
          end else begin
            alpha_r <= '0;
          end
          state_r <= S_SHR2;
        end
        S_SHR2: begin
          shrink_r <= sat33(Q16_ONE - {round_q16($signed(el_r))});
          idx_r    <= '0;
          state_r  <= S_WRD;
        end
        S_WRD: begin
          if (idx_r == pos_r) begin
            if (alpha_r != '0) begin
              bias_r <= sat33({bias_r[31], bias_r} + alpha_r);
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_WM1;
          end
        end
        S_WM1: begin
          prod_r  <= w_cur * shrink_r;
          state_r <= S_WM2;
        end
        S_WM2: begin
          w1_r    <= round_q16(prod_r);
          prod2_r <= alpha_r * b_q;
          state_r <= S_WWR;
        end
        S_WWR: begin
          wvalid_r[idx_r[IW-1:0]] <= 1'b1;
          idx_r   <= idx_r + PW'(1);
          state_r <= S_WRD;
        end
        S_DONE: begin
          if (out_load) begin
            out_kind_r   <= op_r;
            out_value_r  <= pred_r;
            out_status_r <= status_r;
            pos_r        <= '0;
            acc_r        <= '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.model_output = out_value_r;
  assign out_ch.tube_status  = out_status_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n) pos_r <= POS_MAX)
    else $error("feature position beyond capacity");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_status_r != 2'd3))
    else $error("invalid tube status on result");
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ch.ready)) |=> pos_r == '0)
    else $error("position not cleared after sample");

endmodule

// ===== rtl/core/svr_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for eta = round(2^32 / d), one quotient bit per cycle.
module svr_div import svr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] divisor,
  output logic        done,
  output logic [30:0] eta
);

  logic [62:0] d_r;
  logic [63:0] rem_r, rem_nxt;
  logic [32:0] q_r;
  logic [5:0]  cnt_r;
  logic        busy_r, fin_r;
  logic [63:0] rem_sh;
  logic [33:0] eta_full;

  always_comb begin
    rem_sh  = {rem_r[62:0], (cnt_r == 6'd32)};
    rem_nxt = rem_sh;
    if (rem_sh >= {1'b0, d_r}) begin
      rem_nxt = rem_sh - {1'b0, d_r};
    end
    eta_full = {1'b0, q_r} + {33'd0, ({rem_r[62:0], 1'b0} >= {1'b0, d_r})};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
        d_r    <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[31:0], (rem_sh >= {1'b0, d_r})};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  assign done = fin_r;
  assign eta  = (eta_full > {3'd0, ETA_MAX}) ? ETA_MAX : eta_full[30:0];

endmodule
